// ===== hdl/ppz_pkg.sv =====
package ppz_pkg;

    localparam int FRAME_WIDTH_DEF  = 512;
    localparam int FRAME_HEIGHT_DEF = 512;

    localparam int NUM_W  = 49;
    localparam int DEN_W  = 33;
    localparam int CNT_W  = 6;
    localparam int DIV_STEPS = NUM_W;

    localparam logic [31:0] CAM_X_RST   = 32'd0;
    localparam logic [31:0] CAM_Y_RST   = 32'd98304;
    localparam logic [31:0] CAM_Z_RST   = 32'hFFFE_0000;
    localparam logic [31:0] SCALE_X_RST = 32'd62548;
    localparam logic [31:0] SCALE_Y_RST = 32'd113512;
    localparam logic [30:0] NEAR_RST    = 31'd66;

    typedef enum logic [2:0] {
        REG_CAM_X   = 3'd0,
        REG_CAM_Y   = 3'd1,
        REG_CAM_Z   = 3'd2,
        REG_SCALE_X = 3'd3,
        REG_SCALE_Y = 3'd4,
        REG_NEAR    = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        OUT_VISIBLE  = 2'd0,
        OUT_OCCLUDED = 2'd1,
        OUT_OFFFRAME = 2'd2,
        OUT_BEHIND   = 2'd3
    } outcome_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_MAP,
        ST_RND,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/ppz_div.sv =====
module ppz_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ppz_pkg::NUM_W-1:0] num,
    input  logic [ppz_pkg::DEN_W-1:0] den,
    output logic                      busy,
    output logic [ppz_pkg::NUM_W-1:0] quo
);
    import ppz_pkg::*;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign busy = busy_reg;
    assign quo  = num_reg;

endmodule

// ===== hdl/point_projection_zbuffer.sv =====
// Projects one colored Q16.16 point per item onto a FRAME_WIDTH x FRAME_HEIGHT
// pixel grid and depth-tests it against an on-chip depth memory. After reset
// the memory is cleared to all ones, during which s_tready stays low;
// register writes are taken as usual. Points are processed one at a time.
// A point behind the camera goes straight to the result load. Any other
// point passes through the 49-step bit-serial divider that forms x/z and
// y/z, then the scale multiply, pixel mapping, rounding and depth memory
// read; an on-screen point then gets the depth compare and, if closer, the
// write-back, and every point ends with the result load. The camera subtract
// is done on accept. A new point can be taken while the previous result is
// still waiting on m_tready.
module point_projection_zbuffer #(
    parameter int FRAME_WIDTH  = ppz_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = ppz_pkg::FRAME_HEIGHT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // point_x, point_y, point_z, red_in, green_in, blue_in
    input  logic [119:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // pixel_col, pixel_row, point_depth, red_out, green_out, blue_out, zero fill
    output logic [79:0]   m_tdata,
    // outcome
    output logic [1:0]    m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import ppz_pkg::*;

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(FRAME_WIDTH);
    localparam int RW    = $clog2(FRAME_HEIGHT);
    localparam logic signed [63:0] FW   = 64'(FRAME_WIDTH);
    localparam logic signed [63:0] FH   = 64'(FRAME_HEIGHT);
    localparam logic signed [63:0] TW32 = 64'sh1_0000_0000;
    localparam logic signed [64:0] LIM40 = 65'sh100_0000_0000;

    logic [31:0] cam_x_reg, cam_y_reg, cam_z_reg, scale_x_reg, scale_y_reg;
    logic [30:0] near_reg;
    logic        cfg_we;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg   <= CAM_X_RST;
            cam_y_reg   <= CAM_Y_RST;
            cam_z_reg   <= CAM_Z_RST;
            scale_x_reg <= SCALE_X_RST;
            scale_y_reg <= SCALE_Y_RST;
            near_reg    <= NEAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_CAM_X:   cam_x_reg   <= pwdata;
                REG_CAM_Y:   cam_y_reg   <= pwdata;
                REG_CAM_Z:   cam_z_reg   <= pwdata;
                REG_SCALE_X: scale_x_reg <= pwdata;
                REG_SCALE_Y: scale_y_reg <= pwdata;
                REG_NEAR:    near_reg    <= pwdata[30:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CAM_X:   prdata = cam_x_reg;
            REG_CAM_Y:   prdata = cam_y_reg;
            REG_CAM_Z:   prdata = cam_z_reg;
            REG_SCALE_X: prdata = scale_x_reg;
            REG_SCALE_Y: prdata = scale_y_reg;
            REG_NEAR:    prdata = {1'b0, near_reg};
            default:     prdata = '0;
        endcase
    end

    state_t state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;

    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic [31:0] depth_reg;
    logic signed [41:0] nx_reg, ny_reg;
    logic signed [63:0] vx_reg, vy_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic        frame_reg;
    outcome_t    outc_reg, outc_next;

    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic        in_acc, out_free, out_load, div_start, div_busy_x, div_busy_y;
    logic [NUM_W-1:0] qx, qy;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, rd_addr;
    logic [31:0] mem_wdata, rd_data;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        outc_next  = outc_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (in_acc)
                    state_next = ST_SETUP;
            ST_SETUP:
            begin
                if (dz_reg <= $signed({2'b00, near_reg}))
                begin
                    outc_next  = OUT_BEHIND;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
                if (!div_busy_x && !div_busy_y)
                    state_next = ST_MUL;
            ST_MUL:  state_next = ST_MAP;
            ST_MAP:  state_next = ST_RND;
            ST_RND:  state_next = ST_READ;
            ST_READ:
            begin
                if (frame_reg)
                    state_next = ST_CMP;
                else
                begin
                    outc_next  = OUT_OFFFRAME;
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                outc_next  = (depth_reg < rd_data) ? OUT_VISIBLE : OUT_OCCLUDED;
                state_next = ST_DONE;
            end
            ST_DONE:
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    logic [NUM_W-1:0] numx, numy;
    logic [32:0] magx, magy;
    logic signed [31:0] px, py;
    logic signed [64:0] mx, my;
    logic signed [63:0] cx, cy, rx, ry;

    function automatic logic signed [31:0] sat_q(input logic neg, input logic [NUM_W-1:0] q);
        logic signed [31:0] res;
        if (neg)
            res = (q > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
        else
            res = (q > NUM_W'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
        return res;
    endfunction

    function automatic logic signed [41:0] sat40(input logic signed [64:0] v);
        logic signed [41:0] res;
        if (v > LIM40)
            res = 42'(LIM40);
        else if (v < -LIM40)
            res = 42'(-LIM40);
        else
            res = v[41:0];
        return res;
    endfunction

    function automatic logic signed [63:0] rnd33(input logic signed [63:0] v);
        logic signed [63:0] res;
        if (v >= 0)
            res = (v + TW32) >>> 33;
        else
            res = -((-v + TW32) >>> 33);
        return res;
    endfunction

    always_comb
    begin
        magx = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        magy = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        numx = {magx, 16'd0};
        numy = {magy, 16'd0};
        px   = sat_q(dx_reg[32], qx);
        py   = sat_q(dy_reg[32], qy);
        mx   = 65'(px) * $signed({33'd0, scale_x_reg});
        my   = 65'(py) * $signed({33'd0, scale_y_reg});
        rx   = rnd33(vx_reg);
        ry   = rnd33(vy_reg);
        cx   = rx;
        cy   = ry;
    end

    ppz_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (numx),
        .den   (dz_reg),
        .busy  (div_busy_x),
        .quo   (qx)
    );

    ppz_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (numy),
        .den   (dz_reg),
        .busy  (div_busy_y),
        .quo   (qy)
    );

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dx_reg <= $signed({s_tdata[31], s_tdata[31:0]})
                      - $signed({cam_x_reg[31], cam_x_reg});
            dy_reg <= $signed({s_tdata[63], s_tdata[63:32]})
                      - $signed({cam_y_reg[31], cam_y_reg});
            dz_reg <= $signed({s_tdata[95], s_tdata[95:64]})
                      - $signed({cam_z_reg[31], cam_z_reg});
            r_reg  <= s_tdata[103:96];
            g_reg  <= s_tdata[111:104];
            b_reg  <= s_tdata[119:112];
        end
        if (state_reg == ST_SETUP)
            depth_reg <= (dz_reg > 33'sh0_FFFF_FFFE) ? 32'hFFFF_FFFE : dz_reg[31:0];
        if (state_reg == ST_MUL)
        begin
            nx_reg <= sat40(mx);
            ny_reg <= sat40(my);
        end
        if (state_reg == ST_MAP)
        begin
            vx_reg <= (64'(nx_reg) + TW32) * FW - TW32;
            vy_reg <= (TW32 - 64'(ny_reg)) * FH - TW32;
        end
        if (state_reg == ST_RND)
        begin
            col_reg   <= cx[CW-1:0];
            row_reg   <= cy[RW-1:0];
            frame_reg <= (cx >= 0) && (cx < FW) && (cy >= 0) && (cy < FH);
        end
        outc_reg <= outc_next;
    end

    logic [63:0] colx, rowx;
    logic [79:0] data_next;

    always_comb
    begin
        colx = 64'(col_reg);
        rowx = 64'(row_reg);
        data_next = '0;
        unique case (outc_next)
            OUT_VISIBLE:
                data_next = {6'd0, b_reg, g_reg, r_reg, depth_reg, rowx[8:0], colx[8:0]};
            OUT_OCCLUDED:
                data_next = {6'd0, 24'd0, depth_reg, rowx[8:0], colx[8:0]};
            OUT_OFFFRAME:
                data_next = {6'd0, 24'd0, depth_reg, 18'd0};
            OUT_BEHIND:
                data_next = '0;
            default:
                data_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= data_next;
            out_user_reg <= outc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    logic [31:0] mem [DEPTH];

    assign rd_addr   = AW'(64'(row_reg) * 64'(FRAME_WIDTH) + 64'(col_reg));
    assign mem_we    = (state_reg == ST_CLEAR)
                       || (state_reg == ST_CMP && depth_reg < rd_data);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg[AW-1:0] : rd_addr;
    assign mem_wdata = (state_reg == ST_CLEAR) ? 32'hFFFF_FFFF : depth_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
            rd_data <= mem[rd_addr];
    end

    a_write_closer: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && mem_we) |-> (depth_reg < rd_data))
        else $error("depth write without a closer point");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwritten before taken");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && outc_next == OUT_BEHIND) |=> (m_tdata == '0))
        else $error("behind camera item carries data");

    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_SETUP))
        else $error("accepted item not started");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !mem_we || mem_wdata == 32'hFFFF_FFFF)
        else $error("clear pass writes wrong value");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import ppz_pkg::*;

    localparam int FW = 512;
    localparam int FH = 512;
    localparam longint TWO32 = 64'sd4294967296;
    localparam longint LIM40 = 64'sd1099511627776;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        outcome_t    outcome;
        logic [8:0]  col;
        logic [8:0]  row;
        logic [31:0] depth;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_result_t;

    typedef struct {
        logic [31:0]   x;
        logic [31:0]   y;
        logic [31:0]   z;
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        bit            typed;
        pixel_result_t res;
    } point_row_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [119:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [79:0]   m_tdata;
    logic [1:0]    m_tuser;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [4:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    logic [31:0] cam_x, cam_y, cam_z, scl_x, scl_y;
    logic [30:0] near_lim;
    logic [31:0] zbuf [int];

    pixel_result_t pending_results [$];
    point_row_t    dir_tab [$];
    int  errors = 0;
    int  src_idle_pct;
    int  snk_stall_pct;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  idle_count = 0;

    point_projection_zbuffer uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint scaled_ratio(longint d, longint dz, logic [31:0] s);
        longint p;
        p = (d * 65536) / dz;
        p = clamp(p, -64'sd2147483648, 64'sd2147483647);
        return clamp(p * longint'({32'd0, s}), -LIM40, LIM40);
    endfunction

    function automatic longint round_q33(longint v);
        if (v >= 0)
            return (v + TWO32) >>> 33;
        return -((-v + TWO32) >>> 33);
    endfunction

    function automatic pixel_result_t project_point(point_row_t p);
        longint dx, dy, dz, nx, ny, col, row;
        logic [31:0] dep, stored;
        int idx;
        pixel_result_t res;
        res = '0;
        dx = longint'($signed(p.x)) - longint'($signed(cam_x));
        dy = longint'($signed(p.y)) - longint'($signed(cam_y));
        dz = longint'($signed(p.z)) - longint'($signed(cam_z));
        if (dz <= longint'({33'd0, near_lim}))
        begin
            res.outcome = OUT_BEHIND;
            return res;
        end
        dep = (dz > 64'sd4294967294) ? 32'hFFFF_FFFE : dz[31:0];
        res.depth = dep;
        nx = scaled_ratio(dx, dz, scl_x);
        ny = scaled_ratio(dy, dz, scl_y);
        col = round_q33((nx + TWO32) * FW - TWO32);
        row = round_q33((TWO32 - ny) * FH - TWO32);
        if (col < 0 || col >= FW || row < 0 || row >= FH)
        begin
            res.outcome = OUT_OFFFRAME;
            return res;
        end
        res.col = col[8:0];
        res.row = row[8:0];
        idx = int'(row) * FW + int'(col);
        stored = zbuf.exists(idx) ? zbuf[idx] : 32'hFFFF_FFFF;
        if (dep < stored)
        begin
            zbuf[idx] = dep;
            res.outcome = OUT_VISIBLE;
            res.red = p.red;
            res.green = p.green;
            res.blue = p.blue;
        end
        else
            res.outcome = OUT_OCCLUDED;
        return res;
    endfunction

    function automatic point_row_t mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
        point_row_t p;
        p.x = x; p.y = y; p.z = z;
        p.red = r; p.green = g; p.blue = b;
        p.typed = 1'b0;
        p.res = '0;
        return p;
    endfunction

    function automatic point_row_t mk_typed(point_row_t p, outcome_t o, logic [8:0] c,
                                            logic [8:0] r, logic [31:0] d, bit colour);
        p.typed = 1'b1;
        p.res = '0;
        p.res.outcome = o;
        p.res.col = c;
        p.res.row = r;
        p.res.depth = d;
        if (colour)
        begin
            p.res.red = p.red;
            p.res.green = p.green;
            p.res.blue = p.blue;
        end
        return p;
    endfunction

    function automatic void add_row(point_row_t p);
        dir_tab.insert(dir_tab.size(), p);
    endfunction

    function automatic point_row_t rand_point();
        point_row_t p;
        int sel;
        longint dz, dx, dy;
        p = mk_point($urandom, $urandom, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            dz = longint'($urandom_range(16384, 1 << 20));
            if ($urandom_range(0, 1))
            begin
                dx = (dz * (longint'($urandom_range(0, 16)) - 8)) / 8;
                dy = (dz * (longint'($urandom_range(0, 16)) - 8)) / 8;
            end
            else
            begin
                dx = longint'($urandom_range(0, 32'(2 * dz))) - dz;
                dy = longint'($urandom_range(0, 32'(2 * dz))) - dz;
            end
            p.x = cam_x + dx[31:0];
            p.y = cam_y + dy[31:0];
            p.z = cam_z + dz[31:0];
        end
        else if (sel < 82)
            p.z = cam_z + {1'b0, near_lim} - $urandom_range(0, 1000);
        return p;
    endfunction

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_CAM_X:   cam_x = val;
            REG_CAM_Y:   cam_y = val;
            REG_CAM_Z:   cam_z = val;
            REG_SCALE_X: scl_x = val;
            REG_SCALE_Y: scl_y = val;
            REG_NEAR:    near_lim = val[30:0];
            default:     ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_camera(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] sx, logic [31:0] sy, logic [31:0] nr);
        reg_write(REG_CAM_X, x);
        reg_write(REG_CAM_Y, y);
        reg_write(REG_CAM_Z, z);
        reg_write(REG_SCALE_X, sx);
        reg_write(REG_SCALE_Y, sy);
        reg_write(REG_NEAR, nr);
    endtask

    task automatic send_point(point_row_t p);
        pixel_result_t res;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p.blue, p.green, p.red, p.z, p.y, p.x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = project_point(p);
        pending_results.insert(pending_results.size(), p.typed ? p.res : res);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_random(int n, int idle, int stall);
        src_idle_pct = idle;
        snk_stall_pct = stall;
        @(negedge clk);
        repeat (n) send_point(rand_point());
        drain();
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item, actual %0h %0h", $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                pixel_result_t e;
                e = pending_results.pop_front();
                check_field("outcome", 32'(e.outcome), 32'(m_tuser));
                check_field("pixel_col", 32'(e.col), 32'(m_tdata[8:0]));
                check_field("pixel_row", 32'(e.row), 32'(m_tdata[17:9]));
                check_field("point_depth", e.depth, m_tdata[49:18]);
                check_field("red_out", 32'(e.red), 32'(m_tdata[57:50]));
                check_field("green_out", 32'(e.green), 32'(m_tdata[65:58]));
                check_field("blue_out", 32'(e.blue), 32'(m_tdata[73:66]));
                check_field("fill", 32'd0, 32'(m_tdata[79:74]));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        src_idle_pct = 0;
        snk_stall_pct = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cam_x = CAM_X_RST;
        cam_y = CAM_Y_RST;
        cam_z = CAM_Z_RST;
        scl_x = SCALE_X_RST;
        scl_y = SCALE_Y_RST;
        near_lim = NEAR_RST;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // camera at reset: on-axis point lands at the frame center
        add_row(mk_typed(mk_point(0, 98304, 0, 8'h12, 8'h34, 8'h56),
                         OUT_VISIBLE, 9'd256, 9'd256, 32'd131072, 1'b1));
        add_row(mk_typed(mk_point(0, 98304, 0, 8'hFF, 8'hFF, 8'hFF),
                         OUT_OCCLUDED, 9'd256, 9'd256, 32'd131072, 1'b0));
        add_row(mk_point(0, 98304, 32'hFFFF_0000, 8'h00, 8'h00, 8'h00));
        add_row(mk_typed(mk_point(0, 98304, 32'hFFFE_0000, 8'hAA, 8'h55, 8'h0F),
                         OUT_BEHIND, 9'd0, 9'd0, 32'd0, 1'b0));
        add_row(mk_typed(mk_point(5, 7, 32'hFFFE_0042, 8'h01, 8'h02, 8'h03),
                         OUT_BEHIND, 9'd0, 9'd0, 32'd0, 1'b0));
        add_row(mk_point(0, 98304, 32'hFFFE_0043, 8'h80, 8'h7F, 8'h01));
        add_row(mk_typed(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                  8'hFF, 8'h00, 8'hFF), OUT_BEHIND, 9'd0, 9'd0, 32'd0, 1'b0));
        add_row(mk_point(32'h7FFF_FFFF, 98304, 0, 8'h11, 8'h22, 8'h33));
        add_row(mk_point(32'h8000_0000, 98304, 0, 8'h11, 8'h22, 8'h33));
        add_row(mk_point(0, 32'h7FFF_FFFF, 0, 8'h44, 8'h55, 8'h66));
        add_row(mk_point(0, 32'h8000_0000, 0, 8'h44, 8'h55, 8'h66));
        add_row(mk_point(0, 98304, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
        add_row(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h01, 8'h80, 8'hFE));
        add_row(mk_point(32'hFFFF_8000, 32'h0001_0000, 0, 8'h10, 8'h20, 8'h30));
        add_row(mk_point(32'h0001_FFFF, 32'h0000_4000, 32'h0000_8000, 8'h10, 8'h20, 8'h30));
        add_row(mk_point(32'hFFFE_0001, 32'h0003_0000, 0, 8'h09, 8'h08, 8'h07));
        add_row(mk_point(32'h0000_0100, 98304, 0, 8'h09, 8'h08, 8'h07));
        add_row(mk_point(32'hFFFF_FF00, 98304, 0, 8'h09, 8'h08, 8'h07));
        add_row(mk_point(32'h0002_0000, 32'h0003_8000, 0, 8'hC0, 8'h0C, 8'hCC));

        foreach (dir_tab[i])
            send_point(dir_tab[i]);
        drain();

        // extremes: far camera, widest scales, zero near limit, depth saturation
        set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'hFF, 8'h00, 8'hAA));
        send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 8'hFF, 8'h55));
        send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 8'h01, 8'h01, 8'h01));
        run_random(40, 0, 0);
        set_camera(0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        run_random(40, 0, 0);
        set_camera(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'd1, 32'd1, 32'h7FFF_FFFF);
        send_point(mk_point(0, 0, 32'h7FFF_FFFF, 8'h10, 8'h20, 8'h30));
        drain();

        set_camera($urandom_range(0, 1 << 21) - (1 << 20), $urandom_range(0, 1 << 21) - (1 << 20),
                   $urandom_range(0, 1 << 21) - (1 << 20), $urandom_range(30000, 140000),
                   $urandom_range(30000, 140000), $urandom_range(0, 4096));
        @(posedge clk);
        hold_req++;
        run_random(480, 0, 0);

        set_camera(CAM_X_RST, CAM_Y_RST, CAM_Z_RST, SCALE_X_RST, SCALE_Y_RST, NEAR_RST);
        run_random(480, 83, 0);

        set_camera($urandom_range(0, 1 << 22) - (1 << 21), $urandom, $urandom_range(0, 1 << 22),
                   $urandom_range(50000, 70000), $urandom_range(100000, 120000), 0);
        run_random(480, 0, 83);

        set_camera($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20), 0,
                   $urandom_range(60000, 200000), $urandom_range(60000, 200000),
                   $urandom_range(0, 65536));
        run_random(480, 33, 33);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ppz_pkg.sv
hdl/ppz_div.sv
hdl/point_projection_zbuffer.sv
verif/testbench.sv
